// ----- sv/gsa_pkg.sv -----
// Shared types, codes and the control store of the generational slot allocator.
package gsa_pkg;

  localparam int IDX_W     = 10;
  localparam int GEN_W     = 16;
  localparam int CNT_W     = IDX_W + 1;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int MAX_SLOTS = 1 << IDX_W;
  localparam int STEP_W    = 5;

  localparam logic [FUNC_W-1:0] FN_CREATE  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DESTROY = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FLUSH   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INIT    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  handle_index;
    logic [GEN_W-1:0]  handle_generation;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot_index;
    logic [GEN_W-1:0]    slot_generation;
    logic                found;
    logic [CNT_W-1:0]    freed_count;
  } out_item_t;

  typedef enum logic [STEP_W-1:0] {
    S_CLR, S_IDLE, S_CR0, S_CR1, S_CR2, S_LK0, S_DS0, S_DS1,
    S_FL0, S_FL1, S_FL2, S_FL3, S_BAD, S_IN0, S_IN1, S_IN2, S_EMIT
  } step_t;

  typedef enum logic [3:0] {
    JC_NONE, JC_ALWAYS, JC_MORE_ALL, JC_MORE_ACT, JC_MORE_PD,
    JC_CANT_POP, JC_BAD_HANDLE, JC_PD_EMPTY, JC_ACT_EMPTY, JC_OUT_FREE
  } jcond_t;

  typedef enum logic [3:0] {
    RM_HOLD, RM_BASE, RM_CREATE, RM_LOOKUP, RM_CHECK, RM_BADFN,
    RM_FLUSH, RM_POPPED, RM_POPGEN, RM_NEWGEN
  } res_mode_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} cnt_op_t;
  typedef enum logic [1:0] {FD_HOLD, FD_CLR, FD_INC, FD_DEC} fd_op_t;
  typedef enum logic [1:0] {PD_HOLD, PD_CLR, PD_PUSH} pd_op_t;
  typedef enum logic [1:0] {GR_NONE, GR_IN, GR_POP} gen_rsel_t;
  typedef enum logic [1:0] {GW_NONE, GW_ZERO_CNT, GW_INC_IDX} gen_wsel_t;
  typedef enum logic [1:0] {OW_NONE, OW_CLR_CNT, OW_SET_POP, OW_CLR_IDX} occ_wsel_t;
  typedef enum logic [1:0] {SW_NONE, SW_CNT, SW_PEND} stk_wsel_t;

  // One control word per microprogram step.
  typedef struct packed {
    jcond_t    jc;
    step_t     target;
    logic      stay;
    logic      dispatch;
    res_mode_t res;
    cnt_op_t   cnt_op;
    fd_op_t    fd_op;
    pd_op_t    pd_op;
    gen_rsel_t gen_rsel;
    logic      occ_rd;
    gen_wsel_t gen_wsel;
    occ_wsel_t occ_wsel;
    logic      stk_rd;
    stk_wsel_t stk_wsel;
    logic      pend_rd;
    logic      init_latch;
    logic      emit;
  } ucode_t;

  // Branch conditions computed by the datapath.
  typedef struct packed {
    logic more_all;
    logic more_act;
    logic more_pd;
    logic cant_pop;
    logic bad_handle;
    logic pd_empty;
    logic act_empty;
  } dp_flags_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t cw;
    cw = '0;
    unique case (s)
      S_CLR: begin
        cw.gen_wsel = GW_ZERO_CNT;
        cw.occ_wsel = OW_CLR_CNT;
        cw.cnt_op   = CNT_INC;
        cw.jc       = JC_MORE_ALL;
        cw.target   = S_CLR;
      end
      S_IDLE: begin
        cw.dispatch = 1'b1;
        cw.gen_rsel = GR_IN;
        cw.occ_rd   = 1'b1;
      end
      S_CR0: begin
        cw.res    = RM_CREATE;
        cw.stk_rd = 1'b1;
        cw.jc     = JC_CANT_POP;
        cw.target = S_EMIT;
      end
      S_CR1: begin
        cw.res      = RM_POPPED;
        cw.fd_op    = FD_DEC;
        cw.gen_rsel = GR_POP;
        cw.occ_wsel = OW_SET_POP;
      end
      S_CR2: begin
        cw.res    = RM_POPGEN;
        cw.jc     = JC_ALWAYS;
        cw.target = S_EMIT;
      end
      S_LK0: begin
        cw.res    = RM_LOOKUP;
        cw.jc     = JC_ALWAYS;
        cw.target = S_EMIT;
      end
      S_DS0: begin
        cw.res    = RM_CHECK;
        cw.jc     = JC_BAD_HANDLE;
        cw.target = S_EMIT;
      end
      S_DS1: begin
        cw.res      = RM_NEWGEN;
        cw.gen_wsel = GW_INC_IDX;
        cw.occ_wsel = OW_CLR_IDX;
        cw.pd_op    = PD_PUSH;
        cw.jc       = JC_ALWAYS;
        cw.target   = S_EMIT;
      end
      S_FL0: begin
        cw.res    = RM_FLUSH;
        cw.cnt_op = CNT_CLR;
        cw.jc     = JC_PD_EMPTY;
        cw.target = S_FL3;
      end
      S_FL1: begin
        cw.pend_rd = 1'b1;
      end
      S_FL2: begin
        cw.stk_wsel = SW_PEND;
        cw.fd_op    = FD_INC;
        cw.cnt_op   = CNT_INC;
        cw.jc       = JC_MORE_PD;
        cw.target   = S_FL1;
      end
      S_FL3: begin
        cw.pd_op  = PD_CLR;
        cw.jc     = JC_ALWAYS;
        cw.target = S_EMIT;
      end
      S_BAD: begin
        cw.res    = RM_BADFN;
        cw.jc     = JC_ALWAYS;
        cw.target = S_EMIT;
      end
      S_IN0: begin
        cw.init_latch = 1'b1;
        cw.cnt_op     = CNT_CLR;
        cw.fd_op      = FD_CLR;
        cw.pd_op      = PD_CLR;
      end
      S_IN1: begin
        cw.res    = RM_BASE;
        cw.jc     = JC_ACT_EMPTY;
        cw.target = S_EMIT;
      end
      S_IN2: begin
        cw.stk_wsel = SW_CNT;
        cw.occ_wsel = OW_CLR_CNT;
        cw.fd_op    = FD_INC;
        cw.cnt_op   = CNT_INC;
        cw.jc       = JC_MORE_ACT;
        cw.target   = S_IN2;
      end
      S_EMIT: begin
        cw.emit   = 1'b1;
        cw.jc     = JC_OUT_FREE;
        cw.target = S_IDLE;
        cw.stay   = 1'b1;
      end
      default: begin
        cw.jc     = JC_ALWAYS;
        cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

  function automatic step_t dispatch_map(input logic [FUNC_W-1:0] func);
    step_t s;
    unique case (func)
      FN_CREATE:  s = S_CR0;
      FN_LOOKUP:  s = S_LK0;
      FN_DESTROY: s = S_DS0;
      FN_FLUSH:   s = S_FL0;
      FN_INIT:    s = S_IN0;
      default:    s = S_BAD;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/generational_slot_allocator_top.sv -----
// Top level of the generational slot allocator: handshakes, register port and output stage.
//
//   Channel   Direction  Handshake                  Payload
//   in_       input      in_valid / in_stall         gsa_pkg::in_item_t (func, handle)
//   out_      output     out_valid / out_stall       gsa_pkg::out_item_t (status .. freed)
//   APB       config     psel, penable, pwrite       slot_count at byte address 0
//
// A microprogram steps through the slot memories one access at a time; each
// memory has one registered read port, so every dependent read costs a step.
// Create pops the free stack, then reads the popped slot's generation; destroy
// checks the handle, then bumps its generation and queues it for release;
// flush moves each pending slot back onto the free stack; initialize pushes
// the slots up to the saturated slot_count. A full, stalled output register
// holds the emit step. The next item is taken the cycle after the load.
// After reset a clearing pass zeroes the generations and occupied marks;
// in_stall stays high through it. A stalled result waits in the output
// register while the next item is already being worked on.
module generational_slot_allocator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gsa_pkg::in_item_t    in_payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gsa_pkg::out_item_t   out_payload,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import gsa_pkg::*;

  // Register index taken from the word address bit.
  localparam logic REG_SLOT_COUNT = 1'b0;

  ucode_t           cw;
  dp_flags_t        flags;
  out_item_t        res;
  out_item_t        out_payload_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] slot_count_r;
  logic             in_accept, out_free, out_load, cfg_wr;

  // Items are taken only while the microprogram waits at its dispatch step.
  assign in_stall  = !cw.dispatch;
  assign in_accept = in_valid && !in_stall;

  // The output register can take a new result when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = cw.emit && out_free;

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  // Register port: always ready, slot_count is the only register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SLOT_COUNT) ? {{(32 - CNT_W){1'b0}}, slot_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= CNT_W'(MAX_SLOTS);
    end else if (cfg_wr && paddr[2] == REG_SLOT_COUNT) begin
      slot_count_r <= pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_payload_r <= res;
    end
  end

  gsa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_func   (in_payload.func),
    .out_free  (out_free),
    .flags     (flags),
    .cw        (cw)
  );

  gsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cw         (cw),
    .in_accept  (in_accept),
    .in_item    (in_payload),
    .slot_count (slot_count_r),
    .flags      (flags),
    .res        (res)
  );

  // Once an item is taken the sequencer leaves its dispatch step.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("item accepted while sequencer stayed at dispatch");

  // A result is only loaded from the emit step, never while taking an item.
  a_emit_not_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !in_accept)
    else $error("result loaded in the same cycle as an item was taken");

  // Found is only reported together with a valid handle.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload.found) |-> (out_payload.status == ST_OK))
    else $error("found set on a failed request");

  // A flush never returns more slots than exist.
  a_freed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.freed_count <= CNT_W'(MAX_SLOTS)))
    else $error("freed count beyond slot capacity");

endmodule

// ----- sv/gsa_seq.sv -----
// Microprogram sequencer: step counter, control store lookup and branch selection.
module gsa_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  logic [gsa_pkg::FUNC_W-1:0]   in_func,
  input  logic                         out_free,
  input  gsa_pkg::dp_flags_t           flags,
  output gsa_pkg::ucode_t              cw
);
  import gsa_pkg::*;

  step_t upc_r;
  step_t upc_nxt;
  logic  take;

  assign cw = ucode_rom(upc_r);

  always_comb begin
    unique case (cw.jc)
      JC_NONE:       take = 1'b0;
      JC_ALWAYS:     take = 1'b1;
      JC_MORE_ALL:   take = flags.more_all;
      JC_MORE_ACT:   take = flags.more_act;
      JC_MORE_PD:    take = flags.more_pd;
      JC_CANT_POP:   take = flags.cant_pop;
      JC_BAD_HANDLE: take = flags.bad_handle;
      JC_PD_EMPTY:   take = flags.pd_empty;
      JC_ACT_EMPTY:  take = flags.act_empty;
      JC_OUT_FREE:   take = out_free;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    if (cw.dispatch) begin
      upc_nxt = in_accept ? dispatch_map(in_func) : upc_r;
    end else if (take) begin
      upc_nxt = cw.target;
    end else if (cw.stay) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = step_t'(STEP_W'(upc_r + 1'b1));
    end
  end

  // Reset starts the microprogram at the memory clearing loop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ----- sv/gsa_dp.sv -----
// Datapath: slot memories, stack and list pointers, and the result register.
module gsa_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gsa_pkg::ucode_t            cw,
  input  logic                       in_accept,
  input  gsa_pkg::in_item_t          in_item,
  input  logic [gsa_pkg::CNT_W-1:0]  slot_count,
  output gsa_pkg::dp_flags_t         flags,
  output gsa_pkg::out_item_t         res
);
  import gsa_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

  logic [GEN_W-1:0] gen_mem  [MAX_SLOTS];
  logic             occ_mem  [MAX_SLOTS];
  logic [IDX_W-1:0] stk_mem  [MAX_SLOTS];
  logic [IDX_W-1:0] pend_mem [MAX_SLOTS];

  in_item_t         item_r;
  out_item_t        res_r;
  out_item_t        res_nxt;
  logic [CNT_W-1:0] active_r, fd_r, pd_r, cnt_r;
  logic             ready_r;
  logic [GEN_W-1:0] gen_rd_r;
  logic             occ_rd_r;
  logic [IDX_W-1:0] stk_rd_r, pend_rd_r;

  logic [CNT_W:0]   cnt_inc;
  logic             in_range, hv, fd_full, pd_full;
  logic [GEN_W-1:0] base_gen, gen_next;

  logic             gen_we, occ_we, occ_wd, stk_we, pend_we;
  logic [IDX_W-1:0] gen_wa, gen_ra, occ_wa, stk_wa, stk_wd;
  logic [GEN_W-1:0] gen_wd;

  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign in_range = {1'b0, item_r.handle_index} < active_r;
  assign hv       = in_range && (gen_rd_r == item_r.handle_generation);
  assign base_gen = in_range ? gen_rd_r : '0;
  assign gen_next = gen_rd_r + 1'b1;
  assign fd_full  = (fd_r == MAX_CNT);
  assign pd_full  = (pd_r == MAX_CNT);

  assign flags.more_all   = cnt_inc < {1'b0, MAX_CNT};
  assign flags.more_act   = cnt_inc < {1'b0, active_r};
  assign flags.more_pd    = cnt_inc < {1'b0, pd_r};
  assign flags.cant_pop   = !ready_r || (fd_r == '0);
  assign flags.bad_handle = !(hv && occ_rd_r);
  assign flags.pd_empty   = (pd_r == '0);
  assign flags.act_empty  = (active_r == '0);

  assign res = res_r;

  // Port selection for the four memories.
  always_comb begin
    gen_we = 1'b0;
    gen_wa = cnt_r[IDX_W-1:0];
    gen_wd = '0;
    unique case (cw.gen_wsel)
      GW_ZERO_CNT: gen_we = 1'b1;
      GW_INC_IDX: begin
        gen_we = 1'b1;
        gen_wa = item_r.handle_index;
        gen_wd = gen_next;
      end
      default: gen_we = 1'b0;
    endcase

    gen_ra = (cw.gen_rsel == GR_POP) ? stk_rd_r : in_item.handle_index;

    occ_we = 1'b0;
    occ_wa = cnt_r[IDX_W-1:0];
    occ_wd = 1'b0;
    unique case (cw.occ_wsel)
      OW_CLR_CNT: occ_we = 1'b1;
      OW_SET_POP: begin
        occ_we = 1'b1;
        occ_wa = stk_rd_r;
        occ_wd = 1'b1;
      end
      OW_CLR_IDX: begin
        occ_we = 1'b1;
        occ_wa = item_r.handle_index;
      end
      default: occ_we = 1'b0;
    endcase

    stk_we = 1'b0;
    stk_wa = cnt_r[IDX_W-1:0];
    stk_wd = cnt_r[IDX_W-1:0];
    unique case (cw.stk_wsel)
      SW_CNT: stk_we = 1'b1;
      SW_PEND: begin
        stk_we = !fd_full;
        stk_wa = fd_r[IDX_W-1:0];
        stk_wd = pend_rd_r;
      end
      default: stk_we = 1'b0;
    endcase

    pend_we = (cw.pd_op == PD_PUSH) && !pd_full;
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (cw.gen_rsel != GR_NONE) begin
      gen_rd_r <= gen_mem[gen_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    if (cw.occ_rd) begin
      occ_rd_r <= occ_mem[in_item.handle_index];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cw.stk_rd) begin
      stk_rd_r <= stk_mem[IDX_W'(fd_r - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pd_r[IDX_W-1:0]] <= item_r.handle_index;
    end
    if (cw.pend_rd) begin
      pend_rd_r <= pend_mem[cnt_r[IDX_W-1:0]];
    end
  end

  // Pointers, counters and the initialized flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      ready_r  <= 1'b0;
      fd_r     <= '0;
      pd_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (cw.init_latch) begin
        active_r <= (slot_count > MAX_CNT) ? MAX_CNT : slot_count;
        ready_r  <= 1'b1;
      end
      unique case (cw.cnt_op)
        CNT_CLR: cnt_r <= '0;
        CNT_INC: cnt_r <= cnt_inc[CNT_W-1:0];
        default: cnt_r <= cnt_r;
      endcase
      unique case (cw.fd_op)
        FD_CLR:  fd_r <= '0;
        FD_INC:  fd_r <= fd_full ? fd_r : fd_r + 1'b1;
        FD_DEC:  fd_r <= fd_r - 1'b1;
        default: fd_r <= fd_r;
      endcase
      unique case (cw.pd_op)
        PD_CLR:  pd_r <= '0;
        PD_PUSH: pd_r <= pd_full ? pd_r : pd_r + 1'b1;
        default: pd_r <= pd_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_item;
    end
  end

  // Result register, built up across the steps of one item.
  always_comb begin
    res_nxt = res_r;
    unique case (cw.res)
      RM_BASE, RM_CREATE, RM_LOOKUP, RM_CHECK, RM_BADFN, RM_FLUSH: begin
        res_nxt.status          = ST_OK;
        res_nxt.slot_index      = item_r.handle_index;
        res_nxt.slot_generation = base_gen;
        res_nxt.found           = 1'b0;
        res_nxt.freed_count     = '0;
        if (cw.res == RM_CREATE && flags.cant_pop) begin
          res_nxt.status = ST_NO_SLOT;
        end
        if (cw.res == RM_LOOKUP) begin
          res_nxt.status = hv ? ST_OK : ST_BAD_HANDLE;
          res_nxt.found  = hv && occ_rd_r;
        end
        if (cw.res == RM_CHECK && flags.bad_handle) begin
          res_nxt.status = ST_BAD_HANDLE;
        end
        if (cw.res == RM_BADFN) begin
          res_nxt.status = ST_BAD_HANDLE;
        end
        if (cw.res == RM_FLUSH) begin
          res_nxt.freed_count = pd_r;
        end
      end
      RM_POPPED: res_nxt.slot_index      = stk_rd_r;
      RM_POPGEN: res_nxt.slot_generation = gen_rd_r;
      RM_NEWGEN: res_nxt.slot_generation = gen_next;
      default:   res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// ----- bench/tb_generational_slot_allocator_top.sv -----
// Testbench for the generational slot allocator, checked item by item against a built-in slot map.
`timescale 1ns / 100ps

module tb_generational_slot_allocator_top;
  import gsa_pkg::*;

  // The only register, slot_count, sits at byte address 0.
  localparam logic [2:0] REG_SLOT_COUNT = 3'd0;
  // Longest stretch without any handshake: the clearing pass after reset, a full
  // initialize of 1024 slots and the long receiver hold-off all fit well inside it.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_OFF_CYCLES = 200;
  // A drained block needs no more than one full initialize to settle.
  localparam int DRAIN_CYCLES = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_payload = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_payload;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  generational_slot_allocator_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the slot map: generations, live marks, the free stack, the
  // deferred-release list and the latched slot count.
  logic [GEN_W-1:0] slot_gen [MAX_SLOTS];
  logic slot_live [MAX_SLOTS];
  logic [IDX_W-1:0] free_slots [MAX_SLOTS];
  logic [IDX_W-1:0] pend_slots [MAX_SLOTS];
  int unsigned free_top;
  int unsigned pend_top;
  int unsigned live_count;
  logic alloc_ready;
  logic [CNT_W-1:0] slot_count_reg;

  // Both queues are filled at the front and drained from the back.
  in_item_t pending_items [$];
  out_item_t expected_results [$];
  int fail_count = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;

  // Idling patterns: none, sender idle, receiver stalling, both lightly.
  int idle_mode = 0;
  int send_idle_pct [4] = '{0, 70, 0, 7};
  int stall_pct [4] = '{0, 0, 70, 7};

  logic [CNT_W-1:0] phase_counts [RANDOM_PHASES] =
    '{11'd1, 11'd5, 11'd16, 11'd0, 11'd64, 11'd2047, 11'd3, 11'd1024};

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Applies one item to the shadow slot map and returns the result it must produce.
  function automatic out_item_t slot_map_step(input in_item_t it);
    out_item_t r;
    logic handle_ok;
    int unsigned idx;
    int unsigned i;
    idx = it.handle_index;
    r = '0;
    r.slot_index = it.handle_index;
    if (idx < live_count) r.slot_generation = slot_gen[idx];
    handle_ok = (idx < live_count) && (slot_gen[idx] == it.handle_generation);
    case (it.func)
      FN_CREATE: begin
        if (!alloc_ready || free_top == 0) begin
          r.status = ST_NO_SLOT;
        end else begin
          free_top--;
          r.slot_index = free_slots[free_top];
          slot_live[r.slot_index] = 1'b1;
          r.slot_generation = slot_gen[r.slot_index];
        end
      end
      FN_LOOKUP: begin
        if (handle_ok) r.found = slot_live[idx];
        else r.status = ST_BAD_HANDLE;
      end
      FN_DESTROY: begin
        if (handle_ok && slot_live[idx]) begin
          slot_gen[idx] = slot_gen[idx] + 1'b1;
          r.slot_generation = slot_gen[idx];
          slot_live[idx] = 1'b0;
          if (pend_top < MAX_SLOTS) begin
            pend_slots[pend_top] = IDX_W'(idx);
            pend_top++;
          end
        end else begin
          r.status = ST_BAD_HANDLE;
        end
      end
      FN_FLUSH: begin
        // Released slots go back in queue order, so the last one released is reused first.
        r.freed_count = CNT_W'(pend_top);
        for (i = 0; i < pend_top; i++) begin
          if (free_top < MAX_SLOTS) begin
            free_slots[free_top] = pend_slots[i];
            free_top++;
          end
        end
        pend_top = 0;
      end
      FN_INIT: begin
        live_count = (slot_count_reg > MAX_SLOTS) ? MAX_SLOTS : slot_count_reg;
        for (i = 0; i < MAX_SLOTS; i++) slot_live[i] = 1'b0;
        free_top = 0;
        for (i = 0; i < live_count; i++) begin
          free_slots[free_top] = IDX_W'(i);
          free_top++;
        end
        pend_top = 0;
        alloc_ready = 1'b1;
        r.slot_generation = (idx < live_count) ? slot_gen[idx] : '0;
      end
      default: r.status = ST_BAD_HANDLE;
    endcase
    return r;
  endfunction

  // Random item. Lookups and destroys mostly carry a live handle taken from the
  // shadow map, sometimes one generation behind; the rest is noise.
  function automatic in_item_t pick_item();
    in_item_t it;
    int roll;
    int tries;
    int unsigned idx;
    it.func = FN_CREATE;
    it.handle_index = IDX_W'($urandom());
    it.handle_generation = GEN_W'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < 34) begin
      it.func = FN_CREATE;
    end else if (roll < 82) begin
      it.func = (roll < 58) ? FN_LOOKUP : FN_DESTROY;
      if ($urandom_range(0, 9) < 8 && live_count > 0) begin
        idx = $urandom_range(0, live_count - 1);
        for (tries = 0; tries < 16 && !slot_live[idx]; tries++) begin
          idx = $urandom_range(0, live_count - 1);
        end
        it.handle_index = IDX_W'(idx);
        it.handle_generation = slot_gen[idx];
        if ($urandom_range(0, 9) == 0) it.handle_generation = slot_gen[idx] - 1'b1;
      end
    end else if (roll < 90) begin
      it.func = FN_FLUSH;
    end else if (roll < 92) begin
      it.func = FN_INIT;
    end else if (roll < 95) begin
      it.func = FUNC_W'($urandom_range(FN_INIT + 1, (1 << FUNC_W) - 1));
    end else begin
      it.func = FUNC_W'($urandom());
    end
    return it;
  endfunction

  task automatic queue_item(input logic [FUNC_W-1:0] f, input int unsigned idx,
                            input int unsigned g);
    in_item_t it;
    it.func = f;
    it.handle_index = IDX_W'(idx);
    it.handle_generation = GEN_W'(g);
    pending_items.push_front(it);
  endtask

  // Waits until every queued item went in and every result came back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic cfg_write(input logic [CNT_W-1:0] value);
    logic [31:0] word;
    word = $urandom();
    word[CNT_W-1:0] = value;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SLOT_COUNT;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    slot_count_reg = value;
  endtask

  task automatic cfg_check_readback();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_SLOT_COUNT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[CNT_W-1:0] !== slot_count_reg) begin
      note_failure($sformatf("slot_count read %0d, expected %0d",
                             prdata[CNT_W-1:0], slot_count_reg));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: predicts each item at the edge where it is taken, then offers the
  // next one unless the sender idles. A stalled item stays on the wires.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_front(slot_map_step(in_payload));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct[idle_mode]) begin
          in_valid <= 1'b1;
          in_payload <= pending_items.pop_back();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result is matched against the oldest prediction.
  // A requested hold-off keeps the output stalled for its whole length.
  always @(posedge clk) begin
    out_item_t want;
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result with nothing expected: %p", out_payload));
      end else begin
        want = expected_results.pop_back();
        if (out_payload.status !== want.status ||
            out_payload.slot_index !== want.slot_index ||
            out_payload.slot_generation !== want.slot_generation ||
            out_payload.found !== want.found ||
            out_payload.freed_count !== want.freed_count) begin
          note_failure($sformatf("result mismatch: expected %p, got %p", want, out_payload));
        end
      end
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct[idle_mode]);
    end
  end

  // Watchdog: any handshake on either channel or the register port restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int p;
    int k;
    for (k = 0; k < MAX_SLOTS; k++) begin
      slot_gen[k] = '0;
      slot_live[k] = 1'b0;
    end
    free_top = 0;
    pend_top = 0;
    live_count = 0;
    alloc_ready = 1'b0;
    slot_count_reg = 11'd1024;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Before initialize: create finds no slot, every handle is invalid, flush
    // frees nothing and the unused function codes are rejected. The handles
    // here also carry the largest index and generation.
    cfg_check_readback();
    @(negedge clk);
    queue_item(FN_CREATE, 0, 0);
    queue_item(FN_LOOKUP, 0, 0);
    queue_item(FN_DESTROY, MAX_SLOTS - 1, (1 << GEN_W) - 1);
    queue_item(FN_FLUSH, MAX_SLOTS - 1, 0);
    queue_item(FUNC_W'(FN_INIT + 1), 0, (1 << GEN_W) - 1);
    queue_item(FUNC_W'(FN_INIT + 2), MAX_SLOTS - 1, 0);
    queue_item(FUNC_W'((1 << FUNC_W) - 1), MAX_SLOTS - 1, (1 << GEN_W) - 1);
    wait_drained();

    // Two slots: slot 1 comes out first, the third create finds the stack empty,
    // a destroyed handle goes stale, a slot is destroyed twice, and a flush
    // brings the slot back with its new generation. Then a second initialize.
    cfg_write(11'd2);
    cfg_check_readback();
    @(negedge clk);
    queue_item(FN_INIT, 1, 0);
    queue_item(FN_CREATE, 0, 0);
    queue_item(FN_CREATE, 0, 0);
    queue_item(FN_CREATE, 0, 0);
    queue_item(FN_LOOKUP, 1, 0);
    queue_item(FN_LOOKUP, 1, 5);
    queue_item(FN_DESTROY, 1, 0);
    queue_item(FN_DESTROY, 1, 0);
    queue_item(FN_DESTROY, 1, 1);
    queue_item(FN_LOOKUP, 1, 1);
    queue_item(FN_FLUSH, 0, 0);
    queue_item(FN_CREATE, 0, 0);
    queue_item(FN_INIT, MAX_SLOTS - 1, 0);
    queue_item(FN_LOOKUP, 0, 0);
    queue_item(FN_FLUSH, 0, 0);

    // Random phases, each with its own slot count, among them zero, the full
    // table and an oversized count that must saturate.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      cfg_write(phase_counts[p]);
      cfg_check_readback();
      @(negedge clk);
      queue_item(FN_INIT, $urandom(), $urandom());
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        while (pending_items.size() >= 2) @(negedge clk);
        // Sender pause: let the block run completely dry once per phase.
        if (k == 40) wait_drained();
        // Receiver hold-off while the sender keeps offering, so the block fills up.
        if (k == 60 && hold_cycles == 0) hold_cycles = HOLD_OFF_CYCLES;
        if (k >= 60 && k < 75) idle_mode = 0;
        else idle_mode = (p + k / 25) % 4;
        pending_items.push_front(pick_item());
      end
    end

    wait_drained();
    idle_mode = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
